[design/bsm_pkg.sv]
// Shared types, codes and opcode tables of the byte stack machine executor.
`default_nettype none

package bsm_pkg;

  localparam int unsigned IdxW = 11;

  typedef enum logic [4:0] {
    OP_HEAD_INC = 5'd1,
    OP_HEAD_DEC = 5'd2,
    OP_TAPE_GET = 5'd3,
    OP_TAPE_PUT = 5'd4,
    OP_PUSH_ONE = 5'd5,
    OP_DOUBLE   = 5'd6,
    OP_JUMP     = 5'd7,
    OP_SELECT   = 5'd8,
    OP_READ_A   = 5'd9,
    OP_PUT_NUM  = 5'd10,
    OP_ADD      = 5'd11,
    OP_SUB      = 5'd12,
    OP_MUL      = 5'd13,
    OP_DIV      = 5'd14,
    OP_READ_B   = 5'd15,
    OP_PUT_CHR  = 5'd16
  } op_e;

  typedef enum logic [2:0] {
    STAT_RUN   = 3'd0,
    STAT_DONE  = 3'd1,
    STAT_BADOP = 3'd2,
    STAT_UNDER = 3'd3,
    STAT_OVER  = 3'd4,
    STAT_DIVZ  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_TREAD,
    S_POP,
    S_OP,
    S_DIV,
    S_DIVQ
  } state_e;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DBL,
    ALU_CMP,
    ALU_DIVSTEP
  } alu_op_e;

  typedef struct packed {
    alu_op_e    op;
    logic [7:0] x;
    logic [7:0] y;
    logic       cin;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] res;
    logic       qbit;
    logic       zero;
    logic       neg;
  } alu_rsp_t;

  function automatic logic op_valid(op_e op);
    logic ok;
    case (op)
      OP_HEAD_INC, OP_HEAD_DEC, OP_TAPE_GET, OP_TAPE_PUT, OP_PUSH_ONE, OP_DOUBLE,
      OP_JUMP, OP_SELECT, OP_READ_A, OP_PUT_NUM, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
      OP_READ_B, OP_PUT_CHR: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [2:0] pops_of(op_e op);
    logic [2:0] n;
    case (op)
      OP_TAPE_PUT, OP_DOUBLE, OP_JUMP, OP_PUT_NUM, OP_PUT_CHR: n = 3'd1;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: n = 3'd2;
      OP_SELECT: n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic grows_stack(op_e op);
    logic g;
    case (op)
      OP_TAPE_GET, OP_PUSH_ONE, OP_READ_A, OP_READ_B: g = 1'b1;
      default: g = 1'b0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

[design/bsm_ram.sv]
// Single-port-write, single-port-read memory with registered read data.
`default_nettype none

module bsm_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[design/bsm_alu.sv]
// Shared byte arithmetic unit: add, subtract, multiply, double, compare, divide step.
`default_nettype none

module bsm_alu (
  input  wire bsm_pkg::alu_req_t req_i,
  output bsm_pkg::alu_rsp_t      rsp_o
);

  import bsm_pkg::*;

  logic [15:0] prod;
  logic [8:0]  part;
  logic [9:0]  diff;

  always_comb begin
    prod  = req_i.x * req_i.y;
    part  = {req_i.x, req_i.cin};
    diff  = {1'b0, part} - {2'b00, req_i.y};
    rsp_o = '0;
    rsp_o.zero = (req_i.x == 8'd0);
    rsp_o.neg  = req_i.x[7];
    case (req_i.op)
      ALU_ADD: rsp_o.res = req_i.x + req_i.y;
      ALU_SUB: rsp_o.res = req_i.x - req_i.y;
      ALU_MUL: rsp_o.res = prod[7:0];
      ALU_DBL: rsp_o.res = {req_i.x[6:0], 1'b0};
      ALU_CMP: rsp_o.res = req_i.x;
      ALU_DIVSTEP: begin
        rsp_o.qbit = ~diff[9];
        rsp_o.res  = diff[9] ? part[7:0] : diff[7:0];
      end
      default: rsp_o.res = req_i.x;
    endcase
  end

endmodule

`default_nettype wire

[design/byte_stack_machine_executor_unit.sv]
// Top level of the byte stack machine executor: sequencer, tape and stack memories.
// Head moves and pushes finish in the execute state, a tape read then reads and operates, and
// popping operations pop one operand per pop state and operate; divide adds its divide steps.
// The sequencer handles one request at a time; the next one is taken the cycle after
// the result is taken, and the stack memory's single read port sets the pop cost.
// After reset a clearing pass zeroes both memories before the first request is accepted;
// configuration writes are taken throughout.
`default_nettype none

module byte_stack_machine_executor_unit #(
  parameter int unsigned TAPE_DEPTH  = 512,
  parameter int unsigned STACK_DEPTH = 512,
  parameter int unsigned PROGRAM_MAX = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        program_length_we_i,
  input  wire logic [10:0] program_length_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [4:0]  opcode_i,
  input  wire logic [7:0]  input_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [10:0] next_index_o,
  output logic             has_output_o,
  output logic      [7:0]  output_byte_o,
  output logic             output_as_number_o,
  output logic      [2:0]  status_o
);

  import bsm_pkg::*;

  localparam int unsigned TW       = $clog2(TAPE_DEPTH);
  localparam int unsigned SAW      = $clog2(STACK_DEPTH);
  localparam int unsigned SW       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MaxDepth = (TAPE_DEPTH > STACK_DEPTH) ? TAPE_DEPTH : STACK_DEPTH;
  localparam int unsigned CW       = $clog2(MaxDepth);
  localparam int unsigned LenCapI  = (PROGRAM_MAX > 2047) ? 2047 : PROGRAM_MAX;
  localparam logic [IdxW-1:0] LenCap    = IdxW'(LenCapI);
  localparam logic [TW-1:0]   TapeLast  = TW'(TAPE_DEPTH - 1);
  localparam logic [SW-1:0]   StackFull = SW'(STACK_DEPTH);
  localparam logic [CW-1:0]   ClrLast   = CW'(MaxDepth - 1);

  state_e            state_q, state_d;
  logic [CW-1:0]     clr_q, clr_d;
  op_e               op_q, op_d;
  logic [7:0]        ib_q, ib_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [7:0]        opnd_q [4];
  logic [7:0]        opnd_d [4];
  logic [7:0]        rem_q, rem_d;
  logic [7:0]        quo_q, quo_d;
  logic [2:0]        dcnt_q, dcnt_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [TW-1:0]     head_q, head_d;
  logic [SW-1:0]     top_q, top_d;
  logic              halted_q, halted_d;
  status_e           hcode_q, hcode_d;
  logic [IdxW-1:0]   len_q;

  logic              out_valid_q, out_valid_d;
  logic [IdxW-1:0]   out_next_q, out_next_d;
  logic              out_has_q, out_has_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_num_q, out_num_d;
  status_e           out_stat_q, out_stat_d;

  logic              t_we;
  logic [TW-1:0]     t_waddr, t_raddr;
  logic [7:0]        t_wdata, t_rdata;
  logic              s_we;
  logic [SAW-1:0]    s_waddr, s_raddr;
  logic [7:0]        s_wdata, s_rdata;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  logic [IdxW-1:0]   len_eff;
  logic [2:0]        pops;
  logic [SW-1:0]     pop_addr;
  logic [SW-1:0]     top_m1, top_m2, top_m4;
  logic              fin, fault;
  status_e           fault_code;
  logic [IdxW-1:0]   fin_next;
  logic              fin_has, fin_num;
  logic [7:0]        fin_byte;
  logic [7:0]        sel_val;
  logic [7:0]        jmp_m1;

  bsm_ram #(.DEPTH(TAPE_DEPTH), .WIDTH(8)) u_tape (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  bsm_ram #(.DEPTH(STACK_DEPTH), .WIDTH(8)) u_stack (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  bsm_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign len_eff  = (len_q > LenCap) ? LenCap : len_q;
  assign pops     = pops_of(op_q);
  assign top_m1   = top_q - SW'(1);
  assign top_m2   = top_q - SW'(2);
  assign top_m4   = top_q - SW'(4);
  assign pop_addr = top_q - SW'(cnt_q) - SW'(2);
  assign jmp_m1   = opnd_q[0] - 8'd1;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    op_d        = op_q;
    ib_d        = ib_q;
    cnt_d       = cnt_q;
    opnd_d      = opnd_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    idx_d       = idx_q;
    head_d      = head_q;
    top_d       = top_q;
    halted_d    = halted_q;
    hcode_d     = hcode_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_next_d  = out_next_q;
    out_has_d   = out_has_q;
    out_byte_d  = out_byte_q;
    out_num_d   = out_num_q;
    out_stat_d  = out_stat_q;

    t_we       = 1'b0;
    t_waddr    = head_q;
    t_wdata    = opnd_q[0];
    t_raddr    = head_q;
    s_we       = 1'b0;
    s_waddr    = top_q[SAW-1:0];
    s_wdata    = opnd_q[0];
    s_raddr    = top_m1[SAW-1:0];
    alu_req    = '{op: ALU_CMP, x: opnd_q[0], y: opnd_q[0], cin: 1'b0};
    sel_val    = opnd_q[3];
    in_ready_o = 1'b0;

    fin        = 1'b0;
    fault      = 1'b0;
    fault_code = STAT_RUN;
    fin_next   = idx_q + IdxW'(1);
    fin_has    = 1'b0;
    fin_byte   = 8'd0;
    fin_num    = 1'b0;

    case (state_q)
      S_CLEAR: begin
        t_we    = ({1'b0, clr_q} < (CW + 1)'(TAPE_DEPTH));
        t_waddr = clr_q[TW-1:0];
        t_wdata = 8'd0;
        s_we    = ({1'b0, clr_q} < (CW + 1)'(STACK_DEPTH));
        s_waddr = clr_q[SAW-1:0];
        s_wdata = 8'd0;
        clr_d   = clr_q + CW'(1);
        if (clr_q == ClrLast) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = ~out_valid_q;
        if (in_valid_i && !out_valid_q) begin
          op_d    = op_e'(opcode_i);
          ib_d    = input_byte_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (halted_q) begin
          fault      = 1'b1;
          fault_code = hcode_q;
        end else if (idx_q >= len_eff) begin
          fault      = 1'b1;
          fault_code = STAT_DONE;
        end else if (!op_valid(op_q)) begin
          fault      = 1'b1;
          fault_code = STAT_BADOP;
        end else if (top_q < SW'(pops)) begin
          fault      = 1'b1;
          fault_code = STAT_UNDER;
        end else if (grows_stack(op_q) && top_q >= StackFull) begin
          fault      = 1'b1;
          fault_code = STAT_OVER;
        end else begin
          case (op_q)
            OP_HEAD_INC: begin
              head_d = (head_q == TapeLast) ? '0 : head_q + TW'(1);
              fin    = 1'b1;
            end
            OP_HEAD_DEC: begin
              head_d = (head_q == '0) ? TapeLast : head_q - TW'(1);
              fin    = 1'b1;
            end
            OP_TAPE_GET: begin
              state_d = S_TREAD;
            end
            OP_PUSH_ONE: begin
              s_we    = 1'b1;
              s_wdata = 8'd1;
              top_d   = top_q + SW'(1);
              fin     = 1'b1;
            end
            OP_READ_A, OP_READ_B: begin
              s_we    = 1'b1;
              s_wdata = ib_q;
              top_d   = top_q + SW'(1);
              fin     = 1'b1;
            end
            default: begin
              cnt_d   = 2'd0;
              state_d = S_POP;
            end
          endcase
        end
      end
      S_TREAD: begin
        opnd_d[0] = t_rdata;
        state_d   = S_OP;
      end
      S_POP: begin
        opnd_d[cnt_q] = s_rdata;
        s_raddr       = pop_addr[SAW-1:0];
        if (cnt_q == 2'(pops - 3'd1)) begin
          state_d = S_OP;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      S_OP: begin
        case (op_q)
          OP_TAPE_GET: begin
            s_we  = 1'b1;
            top_d = top_q + SW'(1);
            fin   = 1'b1;
          end
          OP_TAPE_PUT: begin
            t_we  = 1'b1;
            top_d = top_m1;
            fin   = 1'b1;
          end
          OP_DOUBLE: begin
            alu_req.op = ALU_DBL;
            s_we       = 1'b1;
            s_waddr    = top_m1[SAW-1:0];
            s_wdata    = alu_rsp.res;
            fin        = 1'b1;
          end
          OP_JUMP: begin
            top_d = top_m1;
            fin   = 1'b1;
            if (opnd_q[0] != 8'd0) begin
              fin_next = IdxW'(jmp_m1);
            end
          end
          OP_SELECT: begin
            alu_req.op = ALU_CMP;
            if (alu_rsp.neg) begin
              sel_val = opnd_q[1];
            end else if (alu_rsp.zero) begin
              sel_val = opnd_q[2];
            end
            s_we    = 1'b1;
            s_waddr = top_m4[SAW-1:0];
            s_wdata = sel_val;
            top_d   = top_q - SW'(3);
            fin     = 1'b1;
          end
          OP_PUT_NUM, OP_PUT_CHR: begin
            top_d    = top_m1;
            fin      = 1'b1;
            fin_has  = 1'b1;
            fin_byte = opnd_q[0];
            fin_num  = (op_q == OP_PUT_NUM);
          end
          OP_ADD, OP_SUB, OP_MUL: begin
            alu_req.op = (op_q == OP_ADD) ? ALU_ADD : ((op_q == OP_SUB) ? ALU_SUB : ALU_MUL);
            alu_req.x  = opnd_q[1];
            alu_req.y  = opnd_q[0];
            s_we       = 1'b1;
            s_waddr    = top_m2[SAW-1:0];
            s_wdata    = alu_rsp.res;
            top_d      = top_m1;
            fin        = 1'b1;
          end
          OP_DIV: begin
            if (opnd_q[0] == 8'd0) begin
              fault      = 1'b1;
              fault_code = STAT_DIVZ;
            end else begin
              rem_d   = 8'd0;
              quo_d   = opnd_q[1];
              dcnt_d  = 3'd0;
              state_d = S_DIV;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_DIV: begin
        alu_req = '{op: ALU_DIVSTEP, x: rem_q, y: opnd_q[0], cin: quo_q[7]};
        rem_d   = alu_rsp.res;
        quo_d   = {quo_q[6:0], alu_rsp.qbit};
        dcnt_d  = dcnt_q + 3'd1;
        if (dcnt_q == 3'd7) begin
          s_we    = 1'b1;
          s_waddr = top_m2[SAW-1:0];
          s_wdata = alu_rsp.res;
          state_d = S_DIVQ;
        end
      end
      S_DIVQ: begin
        s_we    = 1'b1;
        s_waddr = top_m1[SAW-1:0];
        s_wdata = quo_q;
        fin     = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fault) begin
      state_d     = S_IDLE;
      halted_d    = 1'b1;
      hcode_d     = fault_code;
      out_valid_d = 1'b1;
      out_next_d  = idx_q;
      out_has_d   = 1'b0;
      out_byte_d  = 8'd0;
      out_num_d   = 1'b0;
      out_stat_d  = fault_code;
    end else if (fin) begin
      state_d     = S_IDLE;
      idx_d       = fin_next;
      out_valid_d = 1'b1;
      out_next_d  = fin_next;
      out_has_d   = fin_has;
      out_byte_d  = fin_byte;
      out_num_d   = fin_num;
      if (fin_next >= len_eff) begin
        halted_d   = 1'b1;
        hcode_d    = STAT_DONE;
        out_stat_d = STAT_DONE;
      end else begin
        out_stat_d = STAT_RUN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      dcnt_q      <= '0;
      idx_q       <= '0;
      head_q      <= '0;
      top_q       <= SW'(1);
      halted_q    <= 1'b0;
      hcode_q     <= STAT_RUN;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      dcnt_q      <= dcnt_d;
      idx_q       <= idx_d;
      head_q      <= head_d;
      top_q       <= top_d;
      halted_q    <= halted_d;
      hcode_q     <= hcode_d;
      out_valid_q <= out_valid_d;
      if (program_length_we_i) begin
        len_q <= program_length_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    ib_q       <= ib_d;
    opnd_q     <= opnd_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    out_next_q <= out_next_d;
    out_has_q  <= out_has_d;
    out_byte_q <= out_byte_d;
    out_num_q  <= out_num_d;
    out_stat_q <= out_stat_d;
  end

  assign out_valid_o        = out_valid_q;
  assign next_index_o       = out_next_q;
  assign has_output_o       = out_has_q;
  assign output_byte_o      = out_byte_q;
  assign output_as_number_o = out_num_q;
  assign status_o           = out_stat_q;

  a_ready_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("Request accepted while a result is pending.");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("Halt was cleared.");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o)
    else $error("Request accepted during the clearing pass.");

  a_status_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_RUN) |-> halted_q)
    else $error("Stop status reported without a halt.");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= StackFull)
    else $error("Stack pointer beyond the stack depth.");

endmodule

`default_nettype wire
